FILE: sv/rhv_pkg.sv
// Shared types and constants for the ray horizon visibility march.
// Used by rhv_ctrl, rhv_dp and the top level; depends on nothing else.
package rhv_pkg;

    localparam int CNT_W     = 6;   // step counter, holds up to 63
    localparam int COEF_W    = 32;
    localparam int QUO_BITS  = 39;  // magnitude bits of a slope
    localparam int HADJ_W    = 49;  // signed height after drop, plus eye
    localparam int SLOPE_W   = 40;
    localparam int EYE_W     = 17;
    localparam int START_W   = 24;
    localparam int SKIP_W    = 24;
    localparam int SPACE_W   = 20;
    localparam int SEARCH_W  = 16;
    localparam int ELEV_W    = 21;
    localparam int INDEX_W   = 16;
    localparam int DROP_W    = 47;
    localparam int DROP_FRAC = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EYE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH  = 3'd5;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_MARCH,
        PH_ABANDON
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SC_LD,
        ST_SC,
        ST_D1_LD,
        ST_D1,
        ST_D2_LD,
        ST_D2,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_ACCEPT,
        CMD_MUL_STEP,
        CMD_SCALE_LD,
        CMD_DIV_LD_SLOPE,
        CMD_DIV_STEP,
        CMD_DIV_LD_OBS,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic march;     // accepted request starts or continues a march
        logic out_busy;  // output register holds a result not yet taken
    } dp_status_t;

endpackage

FILE: sv/rhv_ctrl.sv
// Sequencer for the ray horizon march: steps the shared multiplier and divider.
// Depends on rhv_pkg; drives rhv_dp by command.
module rhv_ctrl
    import rhv_pkg::*;
#(
    parameter int DIST_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(DIST_BITS - 1);
    localparam logic [CNT_W-1:0] SC_LAST  = CNT_W'(COEF_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_BITS - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = CMD_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = CMD_ACCEPT;
                    if (status.march)
                    begin
                        state_next = ST_SQ;
                        cnt_next   = SQ_LAST;
                    end
                end
            end
            ST_SQ:
            begin
                cmd      = CMD_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_SC_LD;
            end
            ST_SC_LD:
            begin
                cmd        = CMD_SCALE_LD;
                state_next = ST_SC;
                cnt_next   = SC_LAST;
            end
            ST_SC:
            begin
                cmd      = CMD_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_D1_LD;
            end
            ST_D1_LD:
            begin
                cmd        = CMD_DIV_LD_SLOPE;
                state_next = ST_D1;
                cnt_next   = DIV_LAST;
            end
            ST_D1:
            begin
                cmd      = CMD_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_D2_LD;
            end
            ST_D2_LD:
            begin
                cmd        = CMD_DIV_LD_OBS;
                state_next = ST_D2;
                cnt_next   = DIV_LAST;
            end
            ST_D2:
            begin
                cmd      = CMD_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd        = CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rhv_dp.sv
// Datapath of the ray horizon march: settings, ray state, shift-add multiplier,
// restoring divider and output register. Depends on rhv_pkg; driven by rhv_ctrl.
module rhv_dp
    import rhv_pkg::*;
#(
    parameter int SLOPE_FRAC_BITS = 24,
    parameter int DIST_BITS       = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data,
    input  logic                     ray_start,
    input  logic                     water_flag,
    input  logic                     no_data,
    input  logic signed [ELEV_W-1:0] elevation_cm,
    input  cmd_t                     cmd,
    output dp_status_t               status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     visible,
    output logic [INDEX_W-1:0]       sample_index
);

    localparam int PW = 2 * DIST_BITS + COEF_W;             // product width
    localparam int MW = (DIST_BITS > COEF_W) ? DIST_BITS : COEF_W;
    localparam int RW = DIST_BITS + 1;                       // partial remainder
    localparam int CW = DIST_BITS + QUO_BITS + 1;            // overflow compare
    localparam int NW = HADJ_W + SLOPE_FRAC_BITS;            // scaled dividend
    localparam int INT_SH = QUO_BITS - SLOPE_FRAC_BITS;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    // settings
    logic [EYE_W-1:0]    eye_reg;
    logic [START_W-1:0]  start_reg;
    logic [SKIP_W-1:0]   skip_reg;
    logic [SPACE_W-1:0]  spacing_reg;
    logic [COEF_W-1:0]   coef_reg;
    logic [SEARCH_W-1:0] search_reg;

    // ray state
    phase_t                    phase_reg;
    logic [SEARCH_W-1:0]       water_reg;
    logic [DIST_BITS-1:0]      dist_reg;
    logic signed [SLOPE_W-1:0] max_reg;
    logic [INDEX_W-1:0]        index_reg;

    // per-request work registers
    logic signed [ELEV_W-1:0] h_reg;
    logic [DIST_BITS-1:0]     d_reg;
    logic [PW-1:0]            acc_reg;
    logic [PW-1:0]            mcand_reg;
    logic [MW-1:0]            mplier_reg;
    logic [RW-1:0]            rem_reg;
    logic [QUO_BITS-1:0]      nlow_reg;
    logic [QUO_BITS-1:0]      q_reg;
    logic                     neg_reg;
    logic                     sat_reg;
    logic                     out_valid_reg;
    logic                     vis_reg;
    logic [INDEX_W-1:0]       out_index_reg;

    // search decisions on the incoming request
    phase_t              ph_eff;
    logic [SEARCH_W-1:0] wc_eff;
    logic [SEARCH_W-1:0] wc_inc;
    logic                march;
    logic [DIST_BITS-1:0] d_eff;

    always_comb
    begin
        ph_eff = ray_start ? PH_SEARCH : phase_reg;
        wc_eff = ray_start ? '0 : water_reg;
        wc_inc = (wc_eff == '1) ? wc_eff : wc_eff + 1'b1;
        march  = (ph_eff == PH_MARCH) || ((ph_eff == PH_SEARCH) && !water_flag);
        d_eff  = (ph_eff == PH_SEARCH) ? DIST_BITS'(start_reg) : dist_reg;
    end

    assign status.march    = march;
    assign status.out_busy = out_valid_reg && !out_ready;

    // drop and adjusted height
    logic [PW-1:0]             prod_hi;
    logic [DROP_W-1:0]         drop;
    logic signed [HADJ_W-1:0]  hadj;
    logic signed [HADJ_W-1:0]  num;
    logic [HADJ_W-1:0]         mag;
    logic [NW-1:0]             n_full;
    logic [DIST_BITS-1:0]      dd;
    logic                      ovf;

    always_comb
    begin
        prod_hi = acc_reg >> DROP_FRAC;
        if (prod_hi > (PW'(1) << (DROP_W - 1)))
            drop = DROP_W'(1) << (DROP_W - 1);
        else
            drop = prod_hi[DROP_W-1:0];
        hadj = HADJ_W'(h_reg) - $signed(HADJ_W'(drop));
        num  = (cmd == CMD_DIV_LD_OBS) ? hadj + $signed(HADJ_W'(eye_reg)) : hadj;
        mag  = num[HADJ_W-1] ? HADJ_W'(-num) : HADJ_W'(num);
        n_full = NW'(mag) << SLOPE_FRAC_BITS;
        dd   = (d_reg == '0) ? DIST_BITS'(1) : d_reg;
        ovf  = CW'(mag) >= (CW'(dd) << INT_SH);
    end

    // divider step and finished slope
    logic [RW-1:0]             trial;
    logic                      fits;
    logic signed [SLOPE_W-1:0] div_slope;
    logic                      in_skip;
    logic [DIST_BITS:0]        dist_sum;

    always_comb
    begin
        trial = {rem_reg[DIST_BITS-1:0], nlow_reg[QUO_BITS-1]};
        fits  = trial >= RW'(dd);
        if (sat_reg)
            div_slope = neg_reg ? SLOPE_MIN : SLOPE_MAX;
        else if (neg_reg)
            div_slope = -($signed({1'b0, q_reg}) + SLOPE_W'(rem_reg != '0));
        else
            div_slope = $signed({1'b0, q_reg});
        in_skip  = (d_reg < DIST_BITS'(start_reg))
                || ((d_reg - DIST_BITS'(start_reg)) < DIST_BITS'(skip_reg));
        dist_sum = {1'b0, d_reg} + (DIST_BITS+1)'(spacing_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg     <= EYE_W'(170);
            start_reg   <= START_W'(10000);
            skip_reg    <= '0;
            spacing_reg <= SPACE_W'(3000);
            coef_reg    <= COEF_W'(189000);
            search_reg  <= SEARCH_W'(2334);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EYE:     eye_reg     <= cfg_data[EYE_W-1:0];
                REG_START:   start_reg   <= cfg_data[START_W-1:0];
                REG_SKIP:    skip_reg    <= cfg_data[SKIP_W-1:0];
                REG_SPACING: spacing_reg <= cfg_data[SPACE_W-1:0];
                REG_COEF:    coef_reg    <= cfg_data[COEF_W-1:0];
                REG_SEARCH:  search_reg  <= cfg_data[SEARCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            water_reg     <= '0;
            dist_reg      <= '0;
            max_reg       <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a ray start always lands in the search branch
            if (cmd == CMD_ACCEPT && ph_eff == PH_SEARCH)
            begin
                if (water_flag)
                begin
                    water_reg <= wc_inc;
                    // abandon the ray once the search limit is reached
                    phase_reg <= (wc_inc >= search_reg) ? PH_ABANDON : PH_SEARCH;
                end
                else
                begin
                    water_reg <= wc_eff;
                    phase_reg <= PH_MARCH;
                    max_reg   <= '0;
                    index_reg <= '0;
                end
            end
            if (cmd == CMD_DIV_LD_OBS && !in_skip && div_slope > max_reg)
                max_reg <= div_slope;
            if (cmd == CMD_FINISH)
            begin
                out_valid_reg <= 1'b1;
                dist_reg      <= dist_sum[DIST_BITS] ? DIST_MAX : dist_sum[DIST_BITS-1:0];
                if (index_reg != '1)
                    index_reg <= index_reg + 1'b1;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_ACCEPT:
            begin
                h_reg      <= no_data ? '0 : elevation_cm;
                d_reg      <= d_eff;
                acc_reg    <= '0;
                mcand_reg  <= PW'(d_eff);
                mplier_reg <= MW'(d_eff);
            end
            CMD_MUL_STEP:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            CMD_SCALE_LD:
            begin
                acc_reg    <= '0;
                mcand_reg  <= acc_reg;
                mplier_reg <= MW'(coef_reg);
            end
            CMD_DIV_LD_SLOPE, CMD_DIV_LD_OBS:
            begin
                neg_reg  <= num[HADJ_W-1];
                sat_reg  <= ovf;
                rem_reg  <= RW'(n_full >> QUO_BITS);
                nlow_reg <= n_full[QUO_BITS-1:0];
                q_reg    <= '0;
            end
            CMD_DIV_STEP:
            begin
                rem_reg  <= fits ? trial - RW'(dd) : trial;
                q_reg    <= {q_reg[QUO_BITS-2:0], fits};
                nlow_reg <= nlow_reg << 1;
            end
            CMD_FINISH:
            begin
                vis_reg       <= div_slope >= max_reg;
                out_index_reg <= index_reg;
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign visible      = vis_reg;
    assign sample_index = out_index_reg;

endmodule

FILE: sv/ray_horizon_visibility_march.sv
// Top level of the ray horizon visibility march: stream ports and config port.
// Depends on rhv_pkg, rhv_ctrl and rhv_dp.
//
// Takes elevation samples along one ray and returns one visibility result per
// marched sample; water samples during the coast search and samples of an
// abandoned ray give no result and end with their accept. A marched sample is
// accepted, then one shift-add multiplier squares the distance one bit per cycle
// and scales it by the 32-bit drop coefficient, then one restoring divider forms
// the terrain slope and the observer slope at one quotient bit per cycle, 39 bits
// each, with a load step before the scaling and before each division, and a
// finish step that waits for a free output register. One sample is worked on at
// a time; a finished result waits in the output register while the next
// sample is taken. Settings may be written only while the block is idle.
module ray_horizon_visibility_march
    import rhv_pkg::*;
#(
    parameter int SLOPE_FRAC_BITS = 24,
    parameter int DIST_BITS       = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [20:0] elevation_cm
    input  logic [2:0]           s_tuser,   // [0] ray_start, [1] water_flag, [2] no_data
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [0] visible, [16:1] sample_index
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cmd_t               cmd;
    dp_status_t         status;
    logic               visible;
    logic [INDEX_W-1:0] sample_index;

    rhv_ctrl #(
        .DIST_BITS (DIST_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhv_dp #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .DIST_BITS       (DIST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ray_start    (s_tuser[0]),
        .water_flag   (s_tuser[1]),
        .no_data      (s_tuser[2]),
        .elevation_cm ($signed(s_tdata[ELEV_W-1:0])),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .visible      (visible),
        .sample_index (sample_index)
    );

    assign m_tdata = {7'd0, sample_index, visible};

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for ray_horizon_visibility_march: stream stimulus,
// a scoreboard class with its own visibility predictor, random idling on both sides.
// Depends on rhv_pkg and the ray_horizon_visibility_march RTL.
class horizon_scoreboard;
    bit [16:0] eye_cm;
    bit [23:0] start_cm;
    bit [23:0] skip_cm;
    bit [19:0] spacing_cm;
    bit [31:0] drop_coef;
    bit [15:0] search_limit;

    rhv_pkg::phase_t phase;
    bit [15:0] water_cnt;
    bit [31:0] dist_cm;
    longint    peak_slope;
    bit [15:0] march_idx;

    bit [16:0] visibility_q[$];   // {sample_index, visible}
    int errors;
    int results_seen;

    function void reset_all();
        eye_cm       = 17'd170;
        start_cm     = 24'd10000;
        skip_cm      = 24'd0;
        spacing_cm   = 20'd3000;
        drop_coef    = 32'd189000;
        search_limit = 16'd2334;
        phase        = rhv_pkg::PH_SEARCH;
        water_cnt    = 0;
        dist_cm      = 0;
        peak_slope   = 0;
        march_idx    = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
        case (idx)
            rhv_pkg::REG_EYE:     eye_cm       = val[16:0];
            rhv_pkg::REG_START:   start_cm     = val[23:0];
            rhv_pkg::REG_SKIP:    skip_cm      = val[23:0];
            rhv_pkg::REG_SPACING: spacing_cm   = val[19:0];
            rhv_pkg::REG_COEF:    drop_coef    = val;
            rhv_pkg::REG_SEARCH:  search_limit = val[15:0];
            default: ;
        endcase
    endfunction

    function longint curvature_drop(bit [31:0] d);
        bit [127:0] p;
        p = {96'b0, d};
        p = p * p;
        p = p * {96'b0, drop_coef};
        p = p >> 48;
        if (p > (128'd1 << 46))
            p = 128'd1 << 46;
        return longint'(p[63:0]);
    endfunction

    // floor(num * 2^24 / d), saturated to 40-bit signed
    function longint slope_of(longint num, bit [31:0] d);
        bit         neg;
        bit [63:0]  mag;
        bit [127:0] dd;
        bit [127:0] quot;
        bit [127:0] rem;
        neg = num < 0;
        mag = neg ? -num : num;
        dd  = (d == 0) ? 128'd1 : {96'b0, d};
        if ({64'b0, mag} / dd >= (128'd1 << 15))
            return neg ? -(longint'(1) << 39) : (longint'(1) << 39) - 1;
        quot = ({64'b0, mag} << 24) / dd;
        rem  = ({64'b0, mag} << 24) % dd;
        if (!neg)
            return longint'(quot[63:0]);
        if (rem != 0)
            quot = quot + 1;
        return -longint'(quot[63:0]);
    endfunction

    function void note_request(bit rs, bit wat, bit nd, bit [20:0] elev);
        longint    h;
        longint    h_adj;
        longint    s;
        longint    obs;
        bit [31:0] d;
        bit        in_skip;
        bit        vis;
        if (rs)
        begin
            phase     = rhv_pkg::PH_SEARCH;
            water_cnt = 0;
        end
        if (phase == rhv_pkg::PH_ABANDON)
            return;
        if (phase == rhv_pkg::PH_SEARCH)
        begin
            if (wat)
            begin
                if (water_cnt != 16'hFFFF)
                    water_cnt++;
                if (water_cnt >= search_limit)
                    phase = rhv_pkg::PH_ABANDON;
                return;
            end
            phase      = rhv_pkg::PH_MARCH;
            dist_cm    = {8'b0, start_cm};
            peak_slope = 0;
            march_idx  = 0;
        end
        h       = nd ? 0 : longint'($signed(elev));
        d       = dist_cm;
        h_adj   = h - curvature_drop(d);
        in_skip = (d < start_cm) || (d - start_cm < skip_cm);
        if (!in_skip)
        begin
            s = slope_of(h_adj, d);
            if (s > peak_slope)
                peak_slope = s;
        end
        obs = slope_of(h_adj + longint'(eye_cm), d);
        vis = obs >= peak_slope;
        visibility_q.insert(visibility_q.size(), {march_idx, vis});
        dist_cm = (32'hFFFFFFFF - d < spacing_cm) ? 32'hFFFFFFFF : d + spacing_cm;
        if (march_idx != 16'hFFFF)
            march_idx++;
    endfunction

    function void check_result(bit [23:0] data);
        bit [16:0] want;
        results_seen++;
        if (visibility_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: visible=%0d index=%0d", data[0], data[16:1]);
            return;
        end
        want = visibility_q.pop_front();
        if (data[0] !== want[0] || data[16:1] !== want[16:1] || data[23:17] !== 7'b0)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected visible=%0d index=%0d, got visible=%0d index=%0d",
                         want[0], want[16:1], data[0], data[16:1]);
        end
    endfunction
endclass

module tb_top;
    import rhv_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // [20:0] elevation_cm
    logic [2:0]           s_tuser;   // [0] ray_start, [1] water_flag, [2] no_data
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [0] visible, [16:1] sample_index
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    horizon_scoreboard sb;
    int  samples_sent;
    int  rays_sent;
    bit  no_gaps;
    bit  stall_done;

    ray_horizon_visibility_march dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send_sample(input bit rs, input bit wat, input bit nd, input int elev);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, elev[20:0]};
        s_tuser  <= {nd, wat, rs};
        do @(posedge clk); while (!s_tready);
        sb.note_request(rs, wat, nd, elev[20:0]);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // let every request finish, including ones that give no result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.visibility_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic int rand_elev();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 2000);
            1: return -int'($urandom_range(1, 50000));
            2: return $urandom_range(850000, 900000);
            default: return int'($urandom_range(0, 950000)) - 50000;
        endcase
    endfunction

    task automatic send_ray(input int max_water);
        int n_water;
        int n_land;
        n_water = $urandom_range(0, max_water);
        n_land  = $urandom_range(1, 14);
        no_gaps = ($urandom_range(0, 3) == 0);
        rays_sent++;
        for (int i = 0; i <= n_water; i++)
            send_sample(i == 0, i < n_water, $urandom_range(0, 9) == 0, rand_elev());
        for (int i = 1; i < n_land; i++)
            send_sample(1'b0, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                        rand_elev());
    endtask

    task automatic random_phase(input int n_items, input int max_water);
        int target;
        target = samples_sent + n_items;
        // carry on the previous ray under the new settings
        for (int i = 0; i < 3; i++)
            send_sample(1'b0, 1'b0, 1'b0, rand_elev());
        while (samples_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                            int'($urandom_range(0, 950000)) - 50000);
            else
                send_ray(max_water);
        end
        drain();
    endtask

    // receiver with random back-pressure and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        stall_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int gap;
            gap = $urandom_range(0, 5);
            if (!stall_done && sb.results_seen >= 60)
                gap = 400;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (gap == 400)
                stall_done = 1'b1;
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            @(negedge clk);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        sb.reset_all();
        samples_sent = 0;
        rays_sent = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: samples before any ray start, extremes, no data, coast search
        send_sample(1'b0, 1'b0, 1'b0, 900000);
        send_sample(1'b0, 1'b1, 1'b0, -50000);
        send_sample(1'b0, 1'b0, 1'b1, 12345);
        send_sample(1'b0, 1'b0, 1'b0, -50000);
        send_sample(1'b1, 1'b1, 1'b0, 0);
        send_sample(1'b0, 1'b1, 1'b1, 0);
        send_sample(1'b0, 1'b0, 1'b0, 0);
        send_sample(1'b0, 1'b0, 1'b0, 900000);
        send_sample(1'b0, 1'b0, 1'b0, 10);
        send_sample(1'b1, 1'b0, 1'b1, -1);
        send_sample(1'b0, 1'b0, 1'b0, 500);
        send_sample(1'b0, 1'b0, 1'b0, -50000);
        drain();

        // abandoned ray with a tiny search limit, then zero limit
        write_reg(REG_SEARCH, 2);
        send_sample(1'b1, 1'b1, 1'b0, 0);
        send_sample(1'b0, 1'b1, 1'b0, 0);
        send_sample(1'b0, 1'b0, 1'b0, 800);
        send_sample(1'b1, 1'b0, 1'b0, 800);
        drain();
        write_reg(REG_SEARCH, 0);
        send_sample(1'b1, 1'b1, 1'b0, 0);
        send_sample(1'b0, 1'b0, 1'b0, 100);
        send_sample(1'b1, 1'b0, 1'b0, 100);
        drain();

        write_reg(REG_SEARCH, 2334);
        random_phase(110, 4);

        write_reg(REG_EYE, 0);
        write_reg(REG_START, 1);
        write_reg(REG_SKIP, 0);
        write_reg(REG_SPACING, 1);
        write_reg(REG_COEF, 0);
        write_reg(REG_SEARCH, 1);
        random_phase(110, 2);

        write_reg(REG_EYE, 100000);
        write_reg(REG_START, 10000000);
        write_reg(REG_SKIP, 10000000);
        write_reg(REG_SPACING, 1000000);
        write_reg(REG_COEF, 32'hFFFFFFFF);
        write_reg(REG_SEARCH, 65535);
        random_phase(110, 4);

        write_reg(REG_SKIP, 0);
        write_reg(REG_SPACING, 1000000);
        write_reg(REG_START, 10000000);
        random_phase(80, 4);

        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_EYE, $urandom_range(0, 100000));
            write_reg(REG_START, (p == 1) ? 20000000 / 2 : $urandom_range(1, 200000));
            write_reg(REG_SKIP, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 60000));
            write_reg(REG_SPACING, $urandom_range(1, 20000));
            write_reg(REG_COEF, $urandom);
            write_reg(REG_SEARCH, (p == 2) ? 0 : $urandom_range(1, 4));
            random_phase(100, 6);
        end

        drain();
        $display("run covered %0d samples in %0d random rays, %0d results checked",
                 samples_sent, rays_sent, sb.results_seen);
        $display("configurations: reset, both extremes, zero search limit, random settings");
        if (sb.errors == 0 && sb.visibility_q.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d mismatches, %0d results still awaited",
                     sb.errors, sb.visibility_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/rhv_pkg.sv
sv/rhv_ctrl.sv
sv/rhv_dp.sv
sv/ray_horizon_visibility_march.sv
verif/tb_top.sv
